### src/dwsf_pkg.sv
// ----------------------------------------------------------------------------
// dwsf_pkg
// Shared types, codes and saturating helpers for the dipole, wall and spring
// force accumulator.
// ----------------------------------------------------------------------------
package dwsf_pkg;

    // default number of atom slots
    localparam int ATOM_SLOTS_DEF = 32;

    // stream widths
    localparam int S_TDATA_W = 280;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 240;
    localparam int M_TUSER_W = 1;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DIPOLE_AXIS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIPOLE_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_GAIN   = 3'd4;

    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIS_W = 2'd3;

    // largest valid atom number
    localparam logic [26:0] TAG_MAX = 27'd100000000;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // input item kinds
    typedef enum logic [1:0] {
        CMD_CHARGE = 2'd0,
        CMD_MOBILE = 2'd1,
        CMD_SITE   = 2'd2,
        CMD_FINISH = 2'd3
    } item_cmd_t;

    // output record kinds
    localparam logic KIND_FORCE  = 1'b0;
    localparam logic KIND_ENERGY = 1'b1;

    // multiply operations of the shared unit
    typedef enum logic [2:0] {
        OP_CHG = 3'd0,  // charge times position
        OP_SPF = 3'd1,  // spring force
        OP_SPD = 3'd2,  // displacement squared
        OP_SPE = 3'd3,  // spring energy
        OP_FDD = 3'd4,  // dipole squared
        OP_FDE = 3'd5,  // dipole energy
        OP_SCQ = 3'd6,  // gain times slot charge
        OP_SLF = 3'd7   // slot dipole force
    } mul_op_t;

    // right shift applied to a product
    typedef enum logic [2:0] {
        SH_0  = 3'd0,
        SH_16 = 3'd1,
        SH_17 = 3'd2,
        SH_47 = 3'd3,
        SH_48 = 3'd4
    } shift_t;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_LOAD, ST_CHG, ST_DLD, ST_SPF, ST_SPD, ST_SPE,
        ST_WR, ST_FDD, ST_FDE, ST_SCAN, ST_SLD, ST_SCQ, ST_SLF, ST_FOUT, ST_EOUT
    } state_t;

    // one slot of the store
    typedef struct packed {
        logic signed [47:0] fx;
        logic signed [47:0] fy;
        logic signed [47:0] fz;
        logic signed [31:0] qsum;
        logic [26:0]        tag;
    } slot_entry_t;

    // controller to datapath
    typedef struct packed {
        logic      capture;
        logic      ram_rd;
        logic      addr_scan;
        logic      load;
        logic      d_load;
        logic      ram_wr;
        logic      mul_start;
        logic      apply;
        mul_op_t   mul_op;
        logic [1:0] axis_j;
        logic      out_force;
        logic      out_energy;
        logic      clear;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        item_cmd_t item_cmd;
        logic      item_ok;
        logic      scan_touched;
        logic      mul_done;
        logic      out_valid;
    } dp_status_t;

    // saturating 64-bit add
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    // force entry plus product, both clamped to 48 bits
    function automatic logic signed [47:0] f48_acc(input logic signed [47:0] f,
                                                   input logic signed [63:0] r);
        logic signed [47:0] c;
        logic signed [48:0] s;
        if (r > 64'(S48_MAX))
            c = S48_MAX;
        else if (r < 64'(S48_MIN))
            c = S48_MIN;
        else
            c = r[47:0];
        s = 49'(f) + 49'(c);
        if (s[48] != s[47])
            return s[48] ? S48_MIN : S48_MAX;
        return s[47:0];
    endfunction

    // charge sum plus charge, clamped to 32 bits
    function automatic logic signed [31:0] q32_acc(input logic signed [31:0] a,
                                                   input logic signed [23:0] q);
        logic signed [32:0] s;
        s = 33'(a) + 33'(q);
        if (s[32] != s[31])
            return s[32] ? S32_MIN : S32_MAX;
        return s[31:0];
    endfunction

endpackage

### src/dipole_wall_spring_forces.sv
// ----------------------------------------------------------------------------
// dipole_wall_spring_forces
// Accumulates dipole, wall and site spring forces per atom slot and a total
// energy, and reports them on a finish command.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  entries | s_tvalid s_tready s_tdata s_tuser    | in
//  records | m_tvalid m_tready m_tdata m_tuser    | out
//          | m_tlast                              |
//  config  | cfg_valid cfg_ready cfg_index cfg_data | in
//
// Every multiply runs on one shared 32x32 unit in four partial products. A
// charge entry takes one multiply, a mobile entry three and a site entry
// three per axis. Finish takes two multiplies, skips each untouched slot and
// takes two multiplies per touched slot, plus output stalls.
// Reset clears the touched flags, sums and configuration at once; the slot
// RAM is not cleared. Entries are taken one at a time; a waiting record in
// the output register does not block the next entry.
// ----------------------------------------------------------------------------
module dipole_wall_spring_forces
    import dwsf_pkg::*;
#(
    parameter int ATOM_SLOTS = ATOM_SLOTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // atom_slot, atom_tag, pos_x, pos_y, pos_z, charge_value, ref_x, ref_y,
    // ref_z, spring_gain, pad
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // command, 2 bits
    input  logic [S_TUSER_W-1:0]   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_tag, force_x, force_y, force_z, total_energy, pad
    output logic [M_TDATA_W-1:0]   m_tdata,
    // record_kind
    output logic [M_TUSER_W-1:0]   m_tuser,
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = (ATOM_SLOTS > 1) ? $clog2(ATOM_SLOTS) : 1;

    ctrl_cmd_t     cmd;
    dp_status_t    status;
    logic [AW-1:0] scan_idx;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    dwsf_ctrl #(
        .ATOM_SLOTS (ATOM_SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .scan_idx (scan_idx)
    );

    dwsf_dp #(
        .ATOM_SLOTS (ATOM_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .scan_idx  (scan_idx),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

### src/dwsf_ram.sv
// ----------------------------------------------------------------------------
// dwsf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dwsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/dwsf_mul.sv
// ----------------------------------------------------------------------------
// dwsf_mul
// Shared signed 64x64 multiplier: one 32x32 partial product a cycle, then a
// constant right shift truncating toward zero and saturation to 64 bits.
// ----------------------------------------------------------------------------
module dwsf_mul
    import dwsf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] op_a,
    input  logic signed [63:0] op_b,
    input  shift_t             shift,
    output logic               done,
    output logic signed [63:0] result
);

    localparam logic [2:0] STEP_LAST = 3'd5;

    logic [63:0]        ua_reg;
    logic [63:0]        ub_reg;
    logic               neg_reg;
    shift_t             sh_reg;
    logic [2:0]         step_reg;
    logic               run_reg;
    logic               done_reg;
    logic [63:0]        pp_reg;
    logic [127:0]       acc_reg;
    logic signed [63:0] res_reg;

    logic [31:0]        a_half;
    logic [31:0]        b_half;
    logic [63:0]        pp_next;
    logic [127:0]       addend;
    logic [127:0]       shifted;
    logic [63:0]        mlo;
    logic [63:0]        limit;
    logic               ovf;
    logic signed [63:0] res_next;

    // partial product of this step
    always_comb
    begin
        a_half  = step_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
        b_half  = step_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
        pp_next = 64'(a_half) * 64'(b_half);
    end

    // place the previous partial product
    always_comb
    begin
        unique case (step_reg)
            3'd1:    addend = {64'd0, pp_reg};
            3'd2,
            3'd3:    addend = {32'd0, pp_reg, 32'd0};
            3'd4:    addend = {pp_reg, 64'd0};
            default: addend = '0;
        endcase
    end

    // shift and saturate the magnitude
    always_comb
    begin
        unique case (sh_reg)
            SH_16:   shifted = acc_reg >> 16;
            SH_17:   shifted = acc_reg >> 17;
            SH_47:   shifted = acc_reg >> 47;
            SH_48:   shifted = acc_reg >> 48;
            default: shifted = acc_reg;
        endcase
        mlo   = shifted[63:0];
        limit = neg_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        ovf   = (shifted[127:64] != 64'd0) || (mlo > limit);
        if (ovf)
            res_next = neg_reg ? S64_MIN : S64_MAX;
        else
            res_next = neg_reg ? -$signed(mlo) : $signed(mlo);
    end

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                if (step_reg == STEP_LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    // operands, products and result
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg  <= op_a[63] ? 64'(-op_a) : 64'(op_a);
            ub_reg  <= op_b[63] ? 64'(-op_b) : 64'(op_b);
            neg_reg <= op_a[63] ^ op_b[63];
            sh_reg  <= shift;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            pp_reg  <= pp_next;
            acc_reg <= acc_reg + addend;
            if (step_reg == STEP_LAST)
            begin
                res_reg <= res_next;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

### src/dwsf_dp.sv
// ----------------------------------------------------------------------------
// dwsf_dp
// Datapath: configuration, item registers, slot store, shared multiplier,
// dipole and energy sums, working slot and output record register.
// ----------------------------------------------------------------------------
module dwsf_dp
    import dwsf_pkg::*;
#(
    parameter int ATOM_SLOTS = ATOM_SLOTS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  ctrl_cmd_t                                    cmd,
    input  logic [((ATOM_SLOTS > 1) ? $clog2(ATOM_SLOTS) : 1)-1:0] scan_idx,
    output dp_status_t                                   status,
    input  logic [S_TDATA_W-1:0]                         s_tdata,
    input  logic [S_TUSER_W-1:0]                         s_tuser,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    output logic [M_TDATA_W-1:0]                         m_tdata,
    output logic [M_TUSER_W-1:0]                         m_tuser,
    output logic                                         m_tlast,
    input  logic                                         cfg_valid,
    input  logic [CFG_IDX_W-1:0]                         cfg_index,
    input  logic [CFG_DATA_W-1:0]                        cfg_data
);

    localparam int AW = (ATOM_SLOTS > 1) ? $clog2(ATOM_SLOTS) : 1;
    localparam int EW = $bits(slot_entry_t);

    // configuration
    logic [1:0]         axis_reg;
    logic signed [31:0] dgain_reg;
    logic signed [31:0] blow_reg;
    logic signed [31:0] bhigh_reg;
    logic [30:0]        wgain_reg;

    // item
    item_cmd_t          icmd_reg;
    logic [4:0]         slot_reg;
    logic [26:0]        tag_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] ref_reg [3];
    logic signed [23:0] q_reg;
    logic [30:0]        k_reg;

    // working slot and temporaries
    logic signed [47:0] wf_reg [3];
    logic signed [31:0] wq_reg;
    logic [26:0]        wtag_reg;
    logic signed [32:0] d_reg;
    logic signed [63:0] t_reg;
    logic signed [63:0] dipole_reg;
    logic signed [63:0] energy_reg;
    logic [ATOM_SLOTS-1:0] touched_reg;
    logic               rd_touched_reg;

    // output record
    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [26:0]        out_tag_reg;
    logic signed [47:0] out_f_reg [3];
    logic signed [63:0] out_e_reg;
    logic               out_last_reg;

    logic [1:0]         eff_axis;
    logic [1:0]         tgt_axis;
    logic signed [31:0] pos_axis;
    logic signed [32:0] x33;
    logic signed [32:0] d_next;
    logic [63:0]        k_cur;
    logic [5:0]         slot_ext;
    logic [AW-1:0]      item_addr;
    logic [AW-1:0]      rd_addr;
    slot_entry_t        wr_entry;
    slot_entry_t        rd_entry;
    logic [EW-1:0]      rd_data;
    logic signed [63:0] mul_a;
    logic signed [63:0] mul_b;
    shift_t             mul_sh;
    logic               mul_done;
    logic signed [63:0] mul_res;

    // axis code three acts as z
    assign eff_axis = (axis_reg == AXIS_W) ? AXIS_Z : axis_reg;
    assign tgt_axis = (icmd_reg == CMD_SITE) ? cmd.axis_j : eff_axis;
    assign pos_axis = pos_reg[eff_axis];
    assign x33      = 33'(pos_axis);
    assign k_cur    = (icmd_reg == CMD_SITE) ? 64'(k_reg) : 64'(wgain_reg);

    assign slot_ext  = {1'b0, slot_reg};
    assign item_addr = slot_ext[AW-1:0];
    assign rd_addr   = cmd.addr_scan ? scan_idx : item_addr;

    // displacement: site spring per axis, or wall outside the band
    always_comb
    begin
        if (icmd_reg == CMD_SITE)
            d_next = 33'(pos_reg[cmd.axis_j]) - 33'(ref_reg[cmd.axis_j]);
        else if (x33 < 33'(blow_reg))
            d_next = x33 - 33'(blow_reg);
        else if (x33 > 33'(bhigh_reg))
            d_next = x33 - 33'(bhigh_reg);
        else
            d_next = '0;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg  <= AXIS_Z;
            dgain_reg <= '0;
            blow_reg  <= '0;
            bhigh_reg <= '0;
            wgain_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DIPOLE_AXIS: axis_reg  <= cfg_data[1:0];
                REG_DIPOLE_GAIN: dgain_reg <= cfg_data;
                REG_BAND_LOW:    blow_reg  <= cfg_data;
                REG_BAND_HIGH:   bhigh_reg <= cfg_data;
                REG_WALL_GAIN:   wgain_reg <= cfg_data[30:0];
                default:         ;
            endcase
        end
    end

    // item capture; tdata fields from bit 0 up
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            icmd_reg   <= item_cmd_t'(s_tuser);
            slot_reg   <= s_tdata[4:0];
            tag_reg    <= s_tdata[31:5];
            pos_reg[0] <= s_tdata[63:32];
            pos_reg[1] <= s_tdata[95:64];
            pos_reg[2] <= s_tdata[127:96];
            q_reg      <= s_tdata[151:128];
            ref_reg[0] <= s_tdata[183:152];
            ref_reg[1] <= s_tdata[215:184];
            ref_reg[2] <= s_tdata[247:216];
            k_reg      <= s_tdata[278:248];
        end
    end

    // slot store
    assign wr_entry = '{fx: wf_reg[0], fy: wf_reg[1], fz: wf_reg[2],
                        qsum: wq_reg, tag: tag_reg};
    assign rd_entry = slot_entry_t'(rd_data);

    dwsf_ram #(
        .WIDTH (EW),
        .DEPTH (ATOM_SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.ram_wr),
        .waddr (item_addr),
        .wdata (wr_entry),
        .re    (cmd.ram_rd),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // touched flags; an untouched slot reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touched_reg    <= '0;
            rd_touched_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ram_rd)
            begin
                rd_touched_reg <= touched_reg[rd_addr];
            end
            if (cmd.clear)
            begin
                touched_reg <= '0;
            end
            else if (cmd.ram_wr)
            begin
                touched_reg[item_addr] <= 1'b1;
            end
        end
    end

    // multiplier operands
    always_comb
    begin
        unique case (cmd.mul_op)
            OP_CHG:
            begin
                mul_a  = 64'(q_reg);
                mul_b  = 64'(pos_axis);
                mul_sh = SH_0;
            end
            OP_SPF:
            begin
                mul_a  = $signed(k_cur);
                mul_b  = -64'(d_reg);
                mul_sh = SH_16;
            end
            OP_SPD:
            begin
                mul_a  = 64'(d_reg);
                mul_b  = 64'(d_reg);
                mul_sh = SH_16;
            end
            OP_SPE:
            begin
                mul_a  = $signed(k_cur);
                mul_b  = t_reg;
                mul_sh = SH_17;
            end
            OP_FDD:
            begin
                mul_a  = dipole_reg;
                mul_b  = dipole_reg;
                mul_sh = SH_48;
            end
            OP_FDE:
            begin
                mul_a  = 64'(dgain_reg);
                mul_b  = t_reg;
                mul_sh = SH_16;
            end
            OP_SCQ:
            begin
                mul_a  = 64'(dgain_reg);
                mul_b  = 64'(wq_reg);
                mul_sh = SH_0;
            end
            OP_SLF:
            begin
                mul_a  = -t_reg;
                mul_b  = dipole_reg;
                mul_sh = SH_47;
            end
            default:
            begin
                mul_a  = '0;
                mul_b  = '0;
                mul_sh = SH_0;
            end
        endcase
    end

    dwsf_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .shift  (mul_sh),
        .done   (mul_done),
        .result (mul_res)
    );

    // dipole and energy sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dipole_reg <= '0;
            energy_reg <= '0;
        end
        else if (cmd.clear)
        begin
            dipole_reg <= '0;
            energy_reg <= '0;
        end
        else if (cmd.apply)
        begin
            if (cmd.mul_op == OP_CHG)
                dipole_reg <= sat_add64(dipole_reg, mul_res);
            if (cmd.mul_op == OP_SPE || cmd.mul_op == OP_FDE)
                energy_reg <= sat_add64(energy_reg, mul_res);
        end
    end

    // working slot, displacement and temporary
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            wf_reg[0] <= rd_touched_reg ? rd_entry.fx : '0;
            wf_reg[1] <= rd_touched_reg ? rd_entry.fy : '0;
            wf_reg[2] <= rd_touched_reg ? rd_entry.fz : '0;
            wq_reg    <= rd_touched_reg ? rd_entry.qsum : '0;
            wtag_reg  <= rd_entry.tag;
        end
        else if (cmd.apply)
        begin
            unique case (cmd.mul_op)
                OP_CHG:  wq_reg <= q32_acc(wq_reg, q_reg);
                OP_SPF:  wf_reg[tgt_axis] <= f48_acc(wf_reg[tgt_axis], mul_res);
                OP_SLF:  wf_reg[eff_axis] <= f48_acc(wf_reg[eff_axis], mul_res);
                OP_SPD,
                OP_FDD,
                OP_SCQ:  t_reg <= mul_res;
                default: ;
            endcase
        end
        if (cmd.d_load)
        begin
            d_reg <= d_next;
        end
    end

    // output record register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_force || cmd.out_energy)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_force)
        begin
            out_kind_reg <= KIND_FORCE;
            out_tag_reg  <= wtag_reg;
            out_f_reg[0] <= wf_reg[0];
            out_f_reg[1] <= wf_reg[1];
            out_f_reg[2] <= wf_reg[2];
            out_e_reg    <= '0;
            out_last_reg <= 1'b0;
        end
        else if (cmd.out_energy)
        begin
            out_kind_reg <= KIND_ENERGY;
            out_tag_reg  <= '0;
            out_f_reg[0] <= '0;
            out_f_reg[1] <= '0;
            out_f_reg[2] <= '0;
            out_e_reg    <= energy_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_e_reg, out_f_reg[2], out_f_reg[1], out_f_reg[0],
                       out_tag_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // status
    assign status.item_cmd     = icmd_reg;
    assign status.item_ok      = (slot_ext < 6'(ATOM_SLOTS)) && (tag_reg != 27'd0)
                                 && (tag_reg <= TAG_MAX);
    assign status.scan_touched = touched_reg[scan_idx];
    assign status.mul_done     = mul_done;
    assign status.out_valid    = out_valid_reg;

endmodule

### src/dwsf_ctrl.sv
// ----------------------------------------------------------------------------
// dwsf_ctrl
// Controller: sequences slot reads and writes, multiply steps, the finish
// scan over the slots and the output records.
// ----------------------------------------------------------------------------
module dwsf_ctrl
    import dwsf_pkg::*;
#(
    parameter int ATOM_SLOTS = ATOM_SLOTS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    input  dp_status_t                                   status,
    output ctrl_cmd_t                                    cmd,
    output logic [((ATOM_SLOTS > 1) ? $clog2(ATOM_SLOTS) : 1)-1:0] scan_idx
);

    localparam int AW = (ATOM_SLOTS > 1) ? $clog2(ATOM_SLOTS) : 1;
    localparam logic [AW-1:0] SCAN_LAST = AW'(ATOM_SLOTS - 1);
    localparam logic [1:0]    J_LAST    = 2'd2;

    state_t        state_reg;
    state_t        state_next;
    logic          issued_reg;
    logic          issued_next;
    logic [1:0]    j_reg;
    logic [1:0]    j_next;
    logic [AW-1:0] scan_reg;
    logic [AW-1:0] scan_next;
    logic          scan_last;

    assign scan_last = (scan_reg == SCAN_LAST);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
            j_reg      <= '0;
            scan_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            j_reg      <= j_next;
            scan_reg   <= scan_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        j_next      = j_reg;
        scan_next   = scan_reg;
        s_tready    = 1'b0;
        cmd         = '0;
        cmd.mul_op  = OP_CHG;
        cmd.axis_j  = j_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                j_next = '0;
                if (status.item_cmd == CMD_FINISH)
                    state_next = ST_FDD;
                else if (status.item_ok)
                begin
                    cmd.ram_rd = 1'b1;
                    state_next = ST_LOAD;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
                if (status.item_cmd == CMD_CHARGE)
                    state_next = ST_CHG;
                else
                begin
                    cmd.d_load = 1'b1;
                    state_next = ST_SPF;
                end
            end
            ST_DLD:
            begin
                cmd.d_load = 1'b1;
                state_next = ST_SPF;
            end
            ST_CHG, ST_SPF, ST_SPD, ST_SPE, ST_FDD, ST_FDE, ST_SCQ, ST_SLF:
            begin
                unique case (state_reg)
                    ST_CHG:  cmd.mul_op = OP_CHG;
                    ST_SPF:  cmd.mul_op = OP_SPF;
                    ST_SPD:  cmd.mul_op = OP_SPD;
                    ST_SPE:  cmd.mul_op = OP_SPE;
                    ST_FDD:  cmd.mul_op = OP_FDD;
                    ST_FDE:  cmd.mul_op = OP_FDE;
                    ST_SCQ:  cmd.mul_op = OP_SCQ;
                    default: cmd.mul_op = OP_SLF;
                endcase
                cmd.mul_start = !issued_reg;
                issued_next   = 1'b1;
                if (status.mul_done)
                begin
                    cmd.apply   = 1'b1;
                    issued_next = 1'b0;
                    unique case (state_reg)
                        ST_CHG:  state_next = ST_WR;
                        ST_SPF:  state_next = ST_SPD;
                        ST_SPD:  state_next = ST_SPE;
                        ST_SPE:
                        begin
                            if (status.item_cmd == CMD_SITE && j_reg != J_LAST)
                            begin
                                j_next     = j_reg + 2'd1;
                                state_next = ST_DLD;
                            end
                            else
                                state_next = ST_WR;
                        end
                        ST_FDD:  state_next = ST_FDE;
                        ST_FDE:
                        begin
                            scan_next  = '0;
                            state_next = ST_SCAN;
                        end
                        ST_SCQ:  state_next = ST_SLF;
                        default: state_next = ST_FOUT;
                    endcase
                end
            end
            ST_WR:
            begin
                cmd.ram_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.addr_scan = 1'b1;
                if (status.scan_touched)
                begin
                    cmd.ram_rd = 1'b1;
                    state_next = ST_SLD;
                end
                else if (scan_last)
                    state_next = ST_EOUT;
                else
                    scan_next = scan_reg + AW'(1);
            end
            ST_SLD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_SCQ;
            end
            ST_FOUT:
            begin
                if (!status.out_valid)
                begin
                    cmd.out_force = 1'b1;
                    if (scan_last)
                        state_next = ST_EOUT;
                    else
                    begin
                        scan_next  = scan_reg + AW'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_EOUT:
            begin
                if (!status.out_valid)
                begin
                    cmd.out_energy = 1'b1;
                    cmd.clear      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign scan_idx = scan_reg;

endmodule
